// ===== design/ngate_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngate_pkg
// Shared constants, types and the exp2 table entry function for the noise gate.
// ----------------------------------------------------------------------------
package ngate_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int HOLD_WIDTH_DEF   = 24;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int MUL_WIDTH        = 32;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GATE_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_THRESHOLD    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ATTACK       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RELEASE      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HOLD         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EXPAND_RATIO = 3'd5;

   localparam logic [30:0] THRESHOLD_RST = 31'd1073742;
   localparam logic [15:0] ATTACK_RST    = 16'd64880;
   localparam logic [15:0] RELEASE_RST   = 16'd65400;
   localparam int          HOLD_RST      = 2400;

   typedef struct packed {
      logic        enable;
      logic [30:0] threshold;
      logic [15:0] attack;
      logic [15:0] rel_coeff;
      logic [15:0] ratio;
   } ngate_cfg_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = x;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bitv > rem) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // entry j is 2^(-2^-(j+1)) in Q0.30
   function automatic logic [29:0] exp_entry(input int j);
      logic [63:0] v;
      v = isqrt64(64'd1 << 59);
      for (int i = 1; i < 16; i++) begin
         if (i <= j) v = isqrt64(v << 30);
      end
      return v[29:0];
   endfunction

endpackage

// ===== design/ngate_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngate_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ngate_mul
   import ngate_pkg::*;
(
   input  logic                   clock,
   input  logic [MUL_WIDTH-1:0]   op_a,
   input  logic [MUL_WIDTH-1:0]   op_b,
   output logic [2*MUL_WIDTH-1:0] prod_ff
);

   logic [2*MUL_WIDTH-1:0] prod_in;

   assign prod_in = {{MUL_WIDTH{1'b0}}, op_a} * {{MUL_WIDTH{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/ngate_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngate_csr
// Configuration registers of the noise gate.
// ----------------------------------------------------------------------------
module ngate_csr
   import ngate_pkg::*;
#(
   parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  wr_data,
   output ngate_cfg_type              cfg,
   output logic [HOLD_WIDTH-1:0]      hold_samples
);

   ngate_cfg_type         cfg_ff;
   logic [HOLD_WIDTH-1:0] hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b1;
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.attack    <= ATTACK_RST;
         cfg_ff.rel_coeff <= RELEASE_RST;
         cfg_ff.ratio     <= 16'd0;
         hold_ff          <= HOLD_WIDTH'(HOLD_RST);
      end else if (wr_en) begin
         case (wr_index)
            REG_GATE_ENABLE:  cfg_ff.enable    <= wr_data[0];
            REG_THRESHOLD:    cfg_ff.threshold <= wr_data[30:0];
            REG_ATTACK:       cfg_ff.attack    <= wr_data[15:0];
            REG_RELEASE:      cfg_ff.rel_coeff <= wr_data[15:0];
            REG_HOLD:         hold_ff          <= wr_data[HOLD_WIDTH-1:0];
            REG_EXPAND_RATIO: cfg_ff.ratio     <= wr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg          = cfg_ff;
   assign hold_samples = hold_ff;

endmodule

// ===== design/ngate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngate_core
// Sequencer and datapath: envelope, gate/hold, log2/exp2 gain, output scale, or bypass when disabled.
// ----------------------------------------------------------------------------
module ngate_core
   import ngate_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int HOLD_WIDTH   = HOLD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ngate_cfg_type           cfg,
   input  logic [HOLD_WIDTH-1:0]   hold_samples,
   input  logic                    start,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  logic                    last,
   output logic                    idle,
   output logic                    done,
   input  logic                    take,
   output logic [SAMPLE_WIDTH-1:0] res_sample,
   output logic                    res_last
);

   localparam int PSR = (2*SAMPLE_WIDTH >= 32) ? 2*SAMPLE_WIDTH - 32 : 0;
   localparam int PSL = (2*SAMPLE_WIDTH >= 32) ? 0 : 32 - 2*SAMPLE_WIDTH;

   localparam logic [4:0] S_IDLE = 5'd0,  S_PWR = 5'd1,  S_ENV = 5'd2,
                          S_ENVM = 5'd3,  S_ENVU = 5'd4, S_GATE = 5'd5,
                          S_TGT = 5'd6,   S_NORM = 5'd7, S_SQ = 5'd8,
                          S_SQU = 5'd9,   S_DIF = 5'd10, S_DM = 5'd11,
                          S_DMU = 5'd12,  S_EX = 5'd13,  S_EXU = 5'd14,
                          S_EXF = 5'd15,  S_GM = 5'd16,  S_GU = 5'd17,
                          S_OUT = 5'd18,  S_RES = 5'd19, S_DONE = 5'd20;

   localparam logic [29:0] EXP_TAB [0:15] = '{
      exp_entry(0),  exp_entry(1),  exp_entry(2),  exp_entry(3),
      exp_entry(4),  exp_entry(5),  exp_entry(6),  exp_entry(7),
      exp_entry(8),  exp_entry(9),  exp_entry(10), exp_entry(11),
      exp_entry(12), exp_entry(13), exp_entry(14), exp_entry(15)};

   logic [4:0]              state_ff, state_in;
   logic [30:0]             env_ff, env_in;
   logic                    open_ff, open_in;
   logic [HOLD_WIDTH-1:0]   hold_ff, hold_in;
   logic [16:0]             gain_ff, gain_in;

   logic [SAMPLE_WIDTH-1:0] mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    last_ff, last_in;
   logic [SAMPLE_WIDTH-1:0] res_ff, res_in;
   logic [30:0]             pwr_ff, pwr_in;
   logic [16:0]             tgt_ff, tgt_in;
   logic [30:0]             m_ff, m_in;
   logic [4:0]              k_ff, k_in;
   logic [15:0]             frac_ff, frac_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic                    sel_ff, sel_in;
   logic [20:0]             lt_ff, lt_in;
   logic [20:0]             le_ff, le_in;
   logic [20:0]             d_ff, d_in;
   logic [24:0]             e_ff, e_in;
   logic [30:0]             g_ff, g_in;

   logic [MUL_WIDTH-1:0]    op_a, op_b;
   logic [2*MUL_WIDTH-1:0]  prod_ff;
   logic [2*MUL_WIDTH-1:0]  pwr_full;
   logic                    env_ge, gain_ge;
   logic [30:0]             env_diff;
   logic [16:0]             gain_diff;
   logic [15:0]             c_env, c_gain;
   logic [31:0]             sq;
   logic [15:0]             frac_nx;
   logic [8:0]              exp_int;
   logic [30:0]             g_sh;
   logic [SAMPLE_WIDTH-1:0] prod_mag;

   ngate_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign env_ge    = env_ff >= pwr_ff;
   assign env_diff  = env_ge ? env_ff - pwr_ff : pwr_ff - env_ff;
   assign c_env     = (pwr_ff > env_ff) ? cfg.attack : cfg.rel_coeff;
   assign gain_ge   = gain_ff >= tgt_ff;
   assign gain_diff = gain_ge ? gain_ff - tgt_ff : tgt_ff - gain_ff;
   assign c_gain    = open_ff ? cfg.attack : cfg.rel_coeff;
   assign pwr_full  = (2*SAMPLE_WIDTH >= 32) ? (prod_ff >> PSR) : (prod_ff << PSL);
   assign sq        = prod_ff[61:30];
   assign frac_nx   = {frac_ff[14:0], sq[31]};
   assign exp_int   = e_ff[24:16];
   assign g_sh      = g_ff >> exp_int[4:0];
   assign prod_mag  = prod_ff[SAMPLE_WIDTH+15:16];

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_PWR: begin
            op_a = MUL_WIDTH'(mag_ff);
            op_b = MUL_WIDTH'(mag_ff);
         end
         S_ENVM: begin
            op_a = MUL_WIDTH'(c_env);
            op_b = MUL_WIDTH'(env_diff);
         end
         S_SQ: begin
            op_a = MUL_WIDTH'(m_ff);
            op_b = MUL_WIDTH'(m_ff);
         end
         S_DM: begin
            op_a = MUL_WIDTH'(d_ff);
            op_b = MUL_WIDTH'(cfg.ratio);
         end
         S_EX: begin
            op_a = MUL_WIDTH'(g_ff);
            op_b = MUL_WIDTH'(EXP_TAB[cnt_ff]);
         end
         S_GM: begin
            op_a = MUL_WIDTH'(c_gain);
            op_b = MUL_WIDTH'(gain_diff);
         end
         S_OUT: begin
            op_a = MUL_WIDTH'(mag_ff);
            op_b = MUL_WIDTH'(gain_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      env_in   = env_ff;
      open_in  = open_ff;
      hold_in  = hold_ff;
      gain_in  = gain_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      pwr_in   = pwr_ff;
      tgt_in   = tgt_ff;
      m_in     = m_ff;
      k_in     = k_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      g_in     = g_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               neg_in  = sample[SAMPLE_WIDTH-1];
               mag_in  = sample[SAMPLE_WIDTH-1] ? ~sample + 1'b1 : sample;
               last_in = last;
               res_in  = sample;
               state_in = cfg.enable ? S_PWR : S_DONE;
            end
         end
         S_PWR:  state_in = S_ENV;
         S_ENV: begin
            pwr_in   = pwr_full[30:0];
            state_in = S_ENVM;
         end
         S_ENVM: state_in = S_ENVU;
         S_ENVU: begin
            env_in   = env_ge ? pwr_ff + prod_ff[46:16] : pwr_ff - prod_ff[46:16];
            state_in = S_GATE;
         end
         S_GATE: begin
            if (env_ff > cfg.threshold) begin
               open_in = 1'b1;
               hold_in = hold_samples;
            end else if (hold_ff != '0) begin
               hold_in = hold_ff - 1'b1;
            end else begin
               open_in = 1'b0;
            end
            state_in = S_TGT;
         end
         S_TGT: begin
            state_in = S_GM;
            if (open_ff) begin
               tgt_in = 17'd65536;
            end else begin
               tgt_in = 17'd0;
               if (cfg.ratio != 16'd0 && env_ff != 31'd0 && env_ff < cfg.threshold) begin
                  m_in     = cfg.threshold;
                  k_in     = 5'd30;
                  sel_in   = 1'b0;
                  state_in = S_NORM;
               end
            end
         end
         // one bit of normalization per cycle
         S_NORM: begin
            if (!m_ff[30]) begin
               m_in = {m_ff[29:0], 1'b0};
               k_in = k_ff - 1'b1;
            end else begin
               cnt_in   = 4'd0;
               frac_in  = 16'd0;
               state_in = S_SQ;
            end
         end
         S_SQ: state_in = S_SQU;
         S_SQU: begin
            frac_in  = frac_nx;
            m_in     = sq[31] ? sq[31:1] : sq[30:0];
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_SQ;
            if (cnt_ff == 4'd15) begin
               if (!sel_ff) begin
                  lt_in    = {k_ff, frac_nx};
                  m_in     = env_ff;
                  k_in     = 5'd30;
                  sel_in   = 1'b1;
                  state_in = S_NORM;
               end else begin
                  le_in    = {k_ff, frac_nx};
                  state_in = S_DIF;
               end
            end
         end
         S_DIF: begin
            d_in     = (lt_ff > le_ff) ? lt_ff - le_ff : 21'd0;
            state_in = S_DM;
         end
         S_DM:  state_in = S_DMU;
         S_DMU: begin
            e_in     = prod_ff[36:12];
            g_in     = 31'd1 << 30;
            cnt_in   = 4'd0;
            state_in = S_EX;
         end
         S_EX:  state_in = S_EXU;
         S_EXU: begin
            if (e_ff[4'd15 - cnt_ff]) g_in = prod_ff[60:30];
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff == 4'd15) ? S_EXF : S_EX;
         end
         S_EXF: begin
            tgt_in   = (exp_int >= 9'd31) ? 17'd0 : g_sh[30:14];
            state_in = S_GM;
         end
         S_GM:  state_in = S_GU;
         S_GU: begin
            gain_in  = gain_ge ? tgt_ff + prod_ff[32:16] : tgt_ff - prod_ff[32:16];
            state_in = S_OUT;
         end
         S_OUT: state_in = S_RES;
         S_RES: begin
            res_in   = neg_ff ? ~prod_mag + 1'b1 : prod_mag;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         env_ff   <= '0;
         open_ff  <= 1'b0;
         hold_ff  <= '0;
         gain_ff  <= '0;
      end else begin
         state_ff <= state_in;
         env_ff   <= env_in;
         open_ff  <= open_in;
         hold_ff  <= hold_in;
         gain_ff  <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      last_ff <= last_in;
      res_ff  <= res_in;
      pwr_ff  <= pwr_in;
      tgt_ff  <= tgt_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      sel_ff  <= sel_in;
      lt_ff   <= lt_in;
      le_ff   <= le_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      g_ff    <= g_in;
   end

   assign idle       = state_ff == S_IDLE;
   assign done       = state_ff == S_DONE;
   assign res_sample = res_ff;
   assign res_last   = last_ff;

endmodule

// ===== design/noise_gate_with_hold_and_expander_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_gate_with_hold_and_expander_unit
// Noise gate with hold and downward expansion on a stream of audio samples.
// ----------------------------------------------------------------------------
// modes: bypass, gate open or full gating, and expansion, which runs two
// normalizations, two 16-step log2 squarings and 16 exp2 steps, all on one
// shared multiplier
// throughput: one sample at a time; the next sample is taken once the
// finished beat has moved into the output register
// reset: synchronous, clears envelope, gate, hold count, gain and handshakes
module noise_gate_with_hold_and_expander_unit
   import ngate_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int HOLD_WIDTH   = HOLD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,   // sample_in
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,   // gated_sample
   output logic                              rsp_tlast,   // frame_end_out
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_wdata
);

   localparam int TDATA_WIDTH = ((SAMPLE_WIDTH+7)/8)*8;

   ngate_cfg_type           cfg;
   logic [HOLD_WIDTH-1:0]   hold_samples;
   logic                    core_idle, core_done, core_take;
   logic [SAMPLE_WIDTH-1:0] core_sample;
   logic                    core_last;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_data_ff;
   logic                    rsp_last_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = core_idle;

   ngate_csr #(.HOLD_WIDTH(HOLD_WIDTH)) u_csr (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (csr_valid),
      .wr_index     (csr_index),
      .wr_data      (csr_wdata),
      .cfg          (cfg),
      .hold_samples (hold_samples)
   );

   ngate_core #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .HOLD_WIDTH(HOLD_WIDTH)) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .hold_samples (hold_samples),
      .start        (req_tvalid && core_idle),
      .sample       (req_tdata[SAMPLE_WIDTH-1:0]),
      .last         (req_tlast),
      .idle         (core_idle),
      .done         (core_done),
      .take         (core_take),
      .res_sample   (core_sample),
      .res_last     (core_last)
   );

   // output register frees once its beat is taken
   assign core_take    = core_done && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = core_take || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_take) begin
         rsp_data_ff <= core_sample;
         rsp_last_ff <= core_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("core took a beat but stayed idle");

   a_idle_not_done: assert property (@(posedge clock) disable iff (reset)
      !(core_idle && core_done))
      else $error("core idle and done together");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      core_done && !core_take |=> core_done)
      else $error("finished result dropped before the output register took it");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      core_take |=> rsp_tvalid)
      else $error("output register not loaded");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and checking for the noise gate with hold and downward expansion.
// Samples go in on the request stream. Each gated sample that comes back is
// compared with the value from a built-in model of the gate. Both streams
// idle and stall at random, and the registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
   import ngate_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // sample_in
   logic        req_tlast;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // gated_sample
   logic        rsp_tlast;   // frame_end_out
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   noise_gate_with_hold_and_expander_unit DUT (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   typedef struct {
      logic [15:0] sample;
      logic        last;
   } gated_beat_type;

   // model state and configuration
   logic        m_enable;
   logic [30:0] m_threshold;
   logic [15:0] m_attack;
   logic [15:0] m_release;
   logic [23:0] m_hold;
   logic [15:0] m_ratio;
   logic [30:0] m_envelope;
   logic        m_open;
   logic [23:0] m_hold_count;
   logic [16:0] m_gain;
   logic [63:0] exp2_steps[16];

   gated_beat_type expected_beats[$];
   int  mismatches;
   int  beats_checked;
   int  beats_sent;
   int  idle_cycles;
   bit  rsp_hold_off;
   bit  timed_out;

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] log2_frac16(logic [63:0] x);
      int unsigned k;
      logic [63:0] m;
      logic [63:0] frac;
      k    = 0;
      frac = 0;
      while (k < 30 && (x >> (k + 1)) != 0) k++;
      m = x << (30 - k);
      for (int i = 0; i < 16; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m    = m >> 1;
         end
      end
      return (64'(k) << 16) | frac;
   endfunction

   function automatic logic [63:0] exp2_neg(logic [63:0] e);
      logic [63:0] g;
      logic [63:0] n;
      g = 64'd1 << 30;
      n = e >> 16;
      for (int j = 0; j < 16; j++)
         if (e[15-j]) g = (g * exp2_steps[j]) >> 30;
      if (n >= 31) return 0;
      return (g >> n) >> 14;
   endfunction

   function automatic logic [63:0] smooth(logic [63:0] v, logic [63:0] x, logic [63:0] c);
      if (v >= x) return x + ((c * (v - x)) >> 16);
      return x - ((c * (x - v)) >> 16);
   endfunction

   function automatic gated_beat_type gate_sample(logic [15:0] raw, logic last);
      gated_beat_type r;
      logic [63:0] mag, power, target, d, lt, le, prod;
      r.last = last;
      if (!m_enable) begin
         r.sample = raw;
         return r;
      end
      mag   = raw[15] ? (64'd65536 - raw) : 64'(raw);
      power = (mag * mag) << 0;
      m_envelope = 31'(smooth(m_envelope, power,
                              power > m_envelope ? m_attack : m_release));
      if (m_envelope > m_threshold) begin
         m_open       = 1'b1;
         m_hold_count = m_hold;
      end else if (m_hold_count > 0) begin
         m_hold_count = m_hold_count - 1;
      end else begin
         m_open = 1'b0;
      end
      target = 65536;
      if (!m_open) begin
         target = 0;
         if (m_ratio != 0 && m_envelope != 0 && m_envelope < m_threshold) begin
            lt     = log2_frac16(m_threshold);
            le     = log2_frac16(m_envelope);
            d      = (lt > le) ? lt - le : 0;
            target = exp2_neg((d * m_ratio) >> 12);
         end
      end
      m_gain = 17'(smooth(m_gain, target, m_open ? m_attack : m_release));
      prod   = (mag * m_gain) >> 16;
      r.sample = raw[15] ? 16'(64'd0 - prod) : prod[15:0];
      return r;
   endfunction

   // leaves csr_valid high so that writes can follow one another
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      case (idx)
         REG_GATE_ENABLE:  m_enable    = value[0];
         REG_THRESHOLD:    m_threshold = value[30:0];
         REG_ATTACK:       m_attack    = value[15:0];
         REG_RELEASE:      m_release   = value[15:0];
         REG_HOLD:         m_hold      = value[23:0];
         REG_EXPAND_RATIO: m_ratio     = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_gate(logic en, logic [30:0] thr, logic [15:0] att,
                               logic [15:0] rel, logic [23:0] hold, logic [15:0] ratio);
      wait_drained();
      write_reg(REG_GATE_ENABLE, 32'(en));
      write_reg(REG_THRESHOLD, 32'(thr));
      write_reg(REG_ATTACK, 32'(att));
      write_reg(REG_RELEASE, 32'(rel));
      write_reg(REG_HOLD, 32'(hold));
      write_reg(REG_EXPAND_RATIO, 32'(ratio));
      csr_valid <= 1'b0;
   endtask

   // the next beat is taken while one waits at the output, so settle out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (160) @(negedge clock);
   endtask

   // leaves req_tvalid high so that beats can follow back to back
   task automatic send_sample(logic [15:0] s, logic last, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= s;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_beats.push_back(gate_sample(s, last));
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_sample(int level);
      case (level)
         0: return 16'($signed($urandom_range(0, 64)) - 32);
         1: return 16'($signed($urandom_range(0, 4000)) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed_extremes();
      logic [15:0] extreme_vals[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                      16'h0001, 16'h5555, 16'haaaa, 16'h8001};
      foreach (extreme_vals[i]) send_sample(extreme_vals[i], i[0]);
      // loud burst then silence: open, hold, close
      program_gate(1, 31'd1073742, 16'd0, 16'd0, 24'd3, 16'd0);
      for (int i = 0; i < 4; i++) send_sample(16'h7fff, 0);
      for (int i = 0; i < 6; i++) send_sample(16'h0000, i == 5);
   endtask

   task automatic test_bypass();
      program_gate(0, 31'd1073742, 16'd64880, 16'd65400, 24'd2400, 16'd0);
      for (int i = 0; i < 40; i++) send_sample(16'($urandom), $urandom_range(0, 1));
   endtask

   task automatic test_zero_threshold();
      program_gate(1, 31'd0, 16'd0, 16'd65535, 24'd0, 16'd4096);
      for (int i = 0; i < 60; i++) send_sample(random_sample($urandom_range(0, 2)),
                                               $urandom_range(0, 1));
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 12; p++) begin
         logic [30:0] thr;
         logic [15:0] att, rel, ratio;
         logic [23:0] hold;
         thr   = (p == 0) ? 31'd1073741824 : 31'($urandom_range(1, 1 << 24));
         att   = (p == 1) ? 16'd65535 : 16'($urandom_range(0, 65535));
         rel   = (p == 2) ? 16'd0 : 16'($urandom_range(30000, 65535));
         hold  = (p == 3) ? 24'hffffff : 24'($urandom_range(0, 40));
         ratio = (p == 4) ? 16'hffff : ((p % 3 == 0) ? 16'd0 : 16'($urandom));
         program_gate(1, thr, att, rel, hold, ratio);
         for (int i = 0; i < 85; i++) send_sample(random_sample($urandom_range(0, 2)),
                                                  $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_backpressure();
      program_gate(1, 31'd1073742, 16'd64880, 16'd65400, 24'd20, 16'd8192);
      fork
         begin
            rsp_hold_off = 1;
            repeat (600) @(posedge clock);
            rsp_hold_off = 0;
         end
         begin
            for (int i = 0; i < 20; i++) send_sample(random_sample(2), 0, 1);
            req_tvalid <= 1'b0;
         end
      join
      // sender pauses until everything has come back
      while (expected_beats.size() != 0) @(negedge clock);
      for (int i = 0; i < 20; i++) send_sample(random_sample(1), 1);
   endtask

   // response side: a random wait before each beat, or a long hold-off
   initial begin
      int wait_left;
      rsp_tready = 1'b0;
      forever begin
         wait_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
         @(negedge clock);
         while (wait_left != 0 || rsp_hold_off) begin
            rsp_tready <= 1'b0;
            if (wait_left != 0) wait_left--;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && !rsp_hold_off);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         gated_beat_type exp_beat;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: %h", rsp_tdata);
         end else begin
            exp_beat = expected_beats.pop_front();
            beats_checked++;
            if (rsp_tdata !== exp_beat.sample || rsp_tlast !== exp_beat.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch beat %0d: expected %h/%b, got %h/%b", beats_checked,
                           exp_beat.sample, exp_beat.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      exp2_steps[0] = floor_sqrt(64'd1 << 59);
      for (int j = 1; j < 16; j++) exp2_steps[j] = floor_sqrt(exp2_steps[j-1] << 30);
      m_enable = 1; m_threshold = THRESHOLD_RST; m_attack = ATTACK_RST;
      m_release = RELEASE_RST; m_hold = 24'(HOLD_RST); m_ratio = 0;
      m_envelope = 0; m_open = 0; m_hold_count = 0; m_gain = 0;
      mismatches = 0; beats_checked = 0; beats_sent = 0; idle_cycles = 0;
      rsp_hold_off = 0; timed_out = 0;
      reset = 1'b1; req_tvalid = 0; req_tdata = 0; req_tlast = 0;
      csr_valid = 0; csr_index = REG_GATE_ENABLE; csr_wdata = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_bypass();
      test_zero_threshold();
      test_random_phases();
      test_backpressure();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("covered %0d samples over bypass, zero threshold, hold and expansion settings,",
               beats_sent);
      $display("with random stalls on both streams and a long output hold-off");
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ngate_pkg.sv
design/ngate_mul.sv
design/ngate_csr.sv
design/ngate_core.sv
design/noise_gate_with_hold_and_expander_unit.sv
tb/sv/tb.sv
